/* src/ced_pkg.sv */
// types and constants for the caret escape decoder
// standalone package, no dependencies
package ced_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned MAX_RES = 3;
    localparam int unsigned CNT_W = 2;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    typedef enum logic [2:0] {
        PH_TEXT = 3'b001,
        PH_ESC  = 3'b010,
        PH_HELD = 3'b100
    } phase_t;

    localparam byte_t CH_BACKSLASH = 8'h5c;
    localparam byte_t CH_N         = 8'h6e;
    localparam byte_t CH_R         = 8'h72;
    localparam byte_t CH_NEWLINE   = 8'h0a;
    localparam byte_t CH_CR        = 8'h0d;
    localparam byte_t CH_A         = 8'h41;
    localparam byte_t CH_H         = 8'h48;
    localparam byte_t CH_Q         = 8'h51;
    localparam byte_t CH_X         = 8'h58;
    localparam byte_t CTRL_OFFSET  = 8'h40;

endpackage

/* src/caret_escape_decoder_core.sv */
// caret escape decoder top level: input register, decode logic, result buffer
// depends on ced_pkg
//
// an accepted input word is held in the input register, then decoded into the result buffer
// throughput: one input word per cycle while each yields at most one word and out_ready
//   is high; a word yielding two or three results holds the input until the single result
//   port has drained the three-entry result buffer down to its last entry
// reset: asynchronous, clears escape state and empties input register and result buffer
module caret_escape_decoder_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  ced_pkg::byte_t in_byte,
    input  logic          in_last,
    output logic          out_valid,
    input  logic          out_ready,
    output ced_pkg::byte_t out_byte,
    output logic          out_last
);
    import ced_pkg::*;

    logic   in_valid_reg;
    byte_t  in_byte_reg;
    logic   in_last_reg;

    phase_t phase_reg, phase_next;
    byte_t  held_reg, held_next;

    byte_t  buf_byte_reg [MAX_RES];
    logic   buf_last_reg [MAX_RES];
    cnt_t   cnt_reg;

    byte_t  res_byte [MAX_RES];
    cnt_t   res_cnt;
    logic   out_fire;
    logic   drained;
    logic   proc_fire;
    logic   in_fire;

    assign out_valid = (cnt_reg != '0);
    assign out_byte  = buf_byte_reg[0];
    assign out_last  = buf_last_reg[0];
    assign out_fire  = out_valid && out_ready;
    assign drained   = (cnt_reg == '0) || ((cnt_reg == cnt_t'(1)) && out_ready);
    assign proc_fire = in_valid_reg && (drained || (res_cnt == '0));
    assign in_ready  = !in_valid_reg || proc_fire;
    assign in_fire   = in_valid && in_ready;

    // decode one word against the escape state
    always_comb
    begin
        byte_t b;
        cnt_t  n;
        logic  is_ctrl;
        b = in_byte_reg;
        n = '0;
        is_ctrl = ((b >= CH_A) && (b <= CH_H)) || ((b >= CH_Q) && (b <= CH_X));
        for (int i = 0; i < MAX_RES; i++)
        begin
            res_byte[i] = '0;
        end
        phase_next = phase_reg;
        held_next  = held_reg;
        unique case (phase_reg)
            PH_ESC:
            begin
                phase_next = PH_TEXT;
                if (b == CH_N)
                begin
                    res_byte[0] = CH_NEWLINE;
                    n = cnt_t'(1);
                end
                else if (b == CH_R)
                begin
                    res_byte[0] = CH_CR;
                    n = cnt_t'(1);
                end
                else if (b == CH_BACKSLASH)
                begin
                    res_byte[0] = CH_BACKSLASH;
                    n = cnt_t'(1);
                end
                else
                begin
                    held_next  = b;
                    phase_next = PH_HELD;
                end
            end
            PH_HELD:
            begin
                if (is_ctrl)
                begin
                    res_byte[0] = b - CTRL_OFFSET;
                    n = cnt_t'(1);
                end
                else
                begin
                    res_byte[0] = CH_BACKSLASH;
                    res_byte[1] = held_reg;
                    res_byte[2] = b;
                    n = cnt_t'(3);
                end
                held_next  = '0;
                phase_next = PH_TEXT;
            end
            default:
            begin
                if (b == CH_BACKSLASH)
                begin
                    phase_next = PH_ESC;
                end
                else
                begin
                    res_byte[0] = b;
                    n = cnt_t'(1);
                    phase_next = PH_TEXT;
                end
            end
        endcase
        // end of string flushes a pending escape raw
        if (in_last_reg)
        begin
            if (phase_next == PH_ESC)
            begin
                res_byte[n] = CH_BACKSLASH;
                n = n + cnt_t'(1);
            end
            else if (phase_next == PH_HELD)
            begin
                res_byte[n] = CH_BACKSLASH;
                n = n + cnt_t'(1);
                res_byte[n] = held_next;
                n = n + cnt_t'(1);
            end
            phase_next = PH_TEXT;
            held_next  = '0;
        end
        res_cnt = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            phase_reg    <= PH_TEXT;
            held_reg     <= '0;
            cnt_reg      <= '0;
            for (int i = 0; i < MAX_RES; i++)
            begin
                buf_last_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (in_fire)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (proc_fire)
            begin
                in_valid_reg <= 1'b0;
            end
            if (proc_fire)
            begin
                phase_reg <= phase_next;
                held_reg  <= held_next;
            end
            if (proc_fire && (res_cnt != '0))
            begin
                cnt_reg <= res_cnt;
                for (int i = 0; i < MAX_RES; i++)
                begin
                    buf_last_reg[i] <= in_last_reg && (cnt_t'(i + 1) == res_cnt);
                end
            end
            else if (out_fire)
            begin
                cnt_reg <= cnt_reg - cnt_t'(1);
                for (int i = 0; i < MAX_RES - 1; i++)
                begin
                    buf_last_reg[i] <= buf_last_reg[i + 1];
                end
                buf_last_reg[MAX_RES-1] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_byte_reg <= in_byte;
            in_last_reg <= in_last;
        end
        if (proc_fire && (res_cnt != '0))
        begin
            for (int i = 0; i < MAX_RES; i++)
            begin
                buf_byte_reg[i] <= res_byte[i];
            end
        end
        else if (out_fire)
        begin
            for (int i = 0; i < MAX_RES - 1; i++)
            begin
                buf_byte_reg[i] <= buf_byte_reg[i + 1];
            end
        end
    end

endmodule
